[hw/rtl/track_table_with_sorted_readout_macros.svh]
// Assertion macros for the track table checker.
// Used by ttsr_chk; no other dependencies.
`ifndef TRACK_TABLE_WITH_SORTED_READOUT_MACROS_SVH
`define TRACK_TABLE_WITH_SORTED_READOUT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define TTSR_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define TTSR_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/ttsr_pkg.sv]
// Shared constants, codes and record types for the track table.
// No dependencies.
package ttsr_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 16;
  localparam int KEY_W    = 64;
  localparam int DUR_W    = 16;
  localparam int TOT_W    = 22;

  typedef enum logic [1:0] {
    FN_ADD,
    FN_REMOVE,
    FN_PLAY_INS,
    FN_PLAY_ARTIST
  } func_t;

  typedef enum logic [1:0] {
    STS_OK,
    STS_FULL,
    STS_NOT_FOUND,
    STS_EMPTY
  } status_t;

  // One table entry, kept in insertion order.
  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] artist;
    logic [DUR_W-1:0] dur;
  } ent_t;

  // One slot of the artist-sorted index: entry position plus its key.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [KEY_W-1:0] key;
  } ord_t;

  typedef struct packed {
    status_t          status;
    logic [ID_W-1:0]  track_id;
    logic [KEY_W-1:0] track_artist;
    logic [DUR_W-1:0] track_duration;
    logic [TOT_W-1:0] running_total;
    logic             last;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_ADD_RD,
    S_ADD_CMP,
    S_REM_SCAN,
    S_REM_ORD,
    S_PLAY_ORD,
    S_PLAY_ENT,
    S_PLAY_EMIT,
    S_RESP
  } ctrl_state_t;

endpackage

[hw/rtl/ttsr_if.sv]
// Valid/ready channel interfaces for commands and results.
// Depends on ttsr_pkg for field widths.
interface ttsr_cmd_if
  import ttsr_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [1:0]       func;
  logic [KEY_W-1:0] artist_key;
  logic [DUR_W-1:0] duration_sec;
  logic [ID_W-1:0]  target_id;

  modport source (output valid, func, artist_key, duration_sec, target_id, input ready);
  modport sink   (input valid, func, artist_key, duration_sec, target_id, output ready);
endinterface

interface ttsr_res_if
  import ttsr_pkg::*;
  ();
  logic             valid;
  logic             ready;
  logic [1:0]       status;
  logic [ID_W-1:0]  track_id;
  logic [KEY_W-1:0] track_artist;
  logic [DUR_W-1:0] track_duration;
  logic [TOT_W-1:0] running_total;
  logic             last;

  modport source (output valid, status, track_id, track_artist, track_duration,
                  running_total, last, input ready);
  modport sink   (input valid, status, track_id, track_artist, track_duration,
                  running_total, last, output ready);
endinterface

[hw/rtl/ttsr_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module ttsr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                   clk,
  input  logic                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]       wdata,
  input  logic                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hw/rtl/ttsr_out.sv]
// Result output register between the sequencer and the result channel.
// Depends on ttsr_pkg and ttsr_res_if.
module ttsr_out
  import ttsr_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  res_t              data,
  output logic              free,
  ttsr_res_if.source        res
);

  logic valid;
  res_t hold;

  assign free = !valid || res.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (load) begin
      valid <= 1'b1;
    end else if (res.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= data;
    end
  end

  assign res.valid          = valid;
  assign res.status         = hold.status;
  assign res.track_id       = hold.track_id;
  assign res.track_artist   = hold.track_artist;
  assign res.track_duration = hold.track_duration;
  assign res.running_total  = hold.running_total;
  assign res.last           = hold.last;

endmodule

[hw/rtl/ttsr_ctrl.sv]
// Command sequencer: add, compacting remove and playback over the entry
// memory and the sorted index memory. Depends on ttsr_pkg and ttsr_cmd_if.
module ttsr_ctrl
  import ttsr_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  ttsr_cmd_if.sink         cmd,
  output logic             ent_we,
  output logic [IDX_W-1:0] ent_waddr,
  output ent_t             ent_wdata,
  output logic             ent_re,
  output logic [IDX_W-1:0] ent_raddr,
  input  ent_t             ent_rdata,
  output logic             ord_we,
  output logic [IDX_W-1:0] ord_waddr,
  output ord_t             ord_wdata,
  output logic             ord_re,
  output logic [IDX_W-1:0] ord_raddr,
  input  ord_t             ord_rdata,
  output logic             out_load,
  output res_t             out_data,
  input  logic             out_free
);

  ctrl_state_t state, state_next;

  logic [CNT_W-1:0] count, count_next;
  logic [ID_W-1:0]  next_id, next_id_next;

  func_t            c_func;
  logic [KEY_W-1:0] c_key;
  logic [DUR_W-1:0] c_dur;
  logic [ID_W-1:0]  c_tid;

  logic [CNT_W-1:0] j, j_next;
  logic [CNT_W-1:0] rptr, rptr_next;
  logic [CNT_W-1:0] dptr, dptr_next;
  logic [CNT_W-1:0] wptr, wptr_next;
  logic             dvalid, dvalid_next;
  logic             found, found_next;
  logic [IDX_W-1:0] fidx, fidx_next;
  logic [CNT_W-1:0] k, k_next;
  logic [TOT_W-1:0] total, total_next;
  status_t          r_status, r_status_next;
  logic [ID_W-1:0]  r_id, r_id_next;

  logic             full, empty, sorted, scan_end, scan_rd, hit, play_last;
  logic [CNT_W-1:0] jprev, dprev, cnt_last;
  logic [TOT_W-1:0] total_sum;

  assign cmd.ready = (state == S_IDLE);

  assign full      = (count == CNT_W'(CAPACITY));
  assign empty     = (count == '0);
  assign sorted    = (c_func == FN_PLAY_ARTIST);
  assign cnt_last  = count - CNT_W'(1);
  assign jprev     = j - CNT_W'(1);
  assign dprev     = dptr - CNT_W'(1);
  assign scan_end  = (dptr == cnt_last);
  assign scan_rd   = (rptr < count);
  assign hit       = !found && (ent_rdata.id == c_tid);
  assign play_last = (k == cnt_last);
  assign total_sum = total + TOT_W'(ent_rdata.dur);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (cmd.valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        unique case (c_func)
          FN_ADD:         state_next = full ? S_RESP : S_ADD_RD;
          FN_REMOVE:      state_next = empty ? S_RESP : S_REM_SCAN;
          FN_PLAY_INS:    state_next = empty ? S_RESP : S_PLAY_ENT;
          FN_PLAY_ARTIST: state_next = empty ? S_RESP : S_PLAY_ORD;
        endcase
      end
      S_ADD_RD: begin
        state_next = (j == '0) ? S_RESP : S_ADD_CMP;
      end
      S_ADD_CMP: begin
        state_next = (ord_rdata.key > c_key) ? S_ADD_RD : S_RESP;
      end
      S_REM_SCAN: begin
        if (dvalid && scan_end) state_next = (found || hit) ? S_REM_ORD : S_RESP;
      end
      S_REM_ORD: begin
        if (dvalid && scan_end) state_next = S_RESP;
      end
      S_PLAY_ORD: state_next = S_PLAY_ENT;
      S_PLAY_ENT: state_next = S_PLAY_EMIT;
      S_PLAY_EMIT: begin
        if (out_free) begin
          if (play_last) state_next = S_IDLE;
          else           state_next = sorted ? S_PLAY_ORD : S_PLAY_ENT;
        end
      end
      S_RESP: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ent_we        = 1'b0;
    ent_waddr     = count[IDX_W-1:0];
    ent_wdata     = ent_rdata;
    ent_re        = 1'b0;
    ent_raddr     = rptr[IDX_W-1:0];
    ord_we        = 1'b0;
    ord_waddr     = j[IDX_W-1:0];
    ord_wdata     = ord_rdata;
    ord_re        = 1'b0;
    ord_raddr     = rptr[IDX_W-1:0];
    out_load      = 1'b0;
    out_data      = '{status: r_status, track_id: r_id, track_artist: '0,
                      track_duration: '0, running_total: '0, last: 1'b1};
    count_next    = count;
    next_id_next  = next_id;
    j_next        = j;
    rptr_next     = rptr;
    dptr_next     = dptr;
    wptr_next     = wptr;
    dvalid_next   = dvalid;
    found_next    = found;
    fidx_next     = fidx;
    k_next        = k;
    total_next    = total;
    r_status_next = r_status;
    r_id_next     = r_id;

    unique case (state)
      S_DECODE: begin
        rptr_next   = '0;
        dvalid_next = 1'b0;
        found_next  = 1'b0;
        k_next      = '0;
        total_next  = '0;
        unique case (c_func)
          FN_ADD: begin
            if (full) begin
              r_status_next = STS_FULL;
              r_id_next     = '0;
            end else begin
              r_status_next = STS_OK;
              r_id_next     = next_id;
              j_next        = count;
              ent_we        = 1'b1;
              ent_wdata     = '{id: next_id, artist: c_key, dur: c_dur};
            end
          end
          FN_REMOVE: begin
            r_status_next = empty ? STS_EMPTY : STS_OK;
            r_id_next     = c_tid;
          end
          FN_PLAY_INS, FN_PLAY_ARTIST: begin
            r_status_next = STS_EMPTY;
            r_id_next     = '0;
          end
        endcase
      end
      S_ADD_RD: begin
        if (j == '0) begin
          ord_we       = 1'b1;
          ord_wdata    = '{idx: count[IDX_W-1:0], key: c_key};
          count_next   = count + CNT_W'(1);
          next_id_next = next_id + ID_W'(1);
        end else begin
          ord_re    = 1'b1;
          ord_raddr = jprev[IDX_W-1:0];
        end
      end
      S_ADD_CMP: begin
        ord_we = 1'b1;
        if (ord_rdata.key > c_key) begin
          // Shift the larger key up one slot and keep walking down.
          ord_wdata = ord_rdata;
          j_next    = jprev;
        end else begin
          ord_wdata    = '{idx: count[IDX_W-1:0], key: c_key};
          count_next   = count + CNT_W'(1);
          next_id_next = next_id + ID_W'(1);
        end
      end
      S_REM_SCAN: begin
        dvalid_next = scan_rd;
        if (scan_rd) begin
          ent_re    = 1'b1;
          rptr_next = rptr + CNT_W'(1);
          dptr_next = rptr;
        end
        if (dvalid) begin
          if (hit) begin
            found_next = 1'b1;
            fidx_next  = dptr[IDX_W-1:0];
          end
          // Past the match: move each entry down one slot.
          if (found) begin
            ent_we    = 1'b1;
            ent_waddr = dprev[IDX_W-1:0];
            ent_wdata = ent_rdata;
          end
          if (scan_end) begin
            rptr_next   = '0;
            dvalid_next = 1'b0;
            wptr_next   = '0;
            if (!(found || hit)) r_status_next = STS_NOT_FOUND;
          end
        end
      end
      S_REM_ORD: begin
        dvalid_next = scan_rd;
        if (scan_rd) begin
          ord_re    = 1'b1;
          rptr_next = rptr + CNT_W'(1);
          dptr_next = rptr;
        end
        if (dvalid) begin
          // Drop the removed slot, renumber the positions above it.
          if (ord_rdata.idx != fidx) begin
            ord_we        = 1'b1;
            ord_waddr     = wptr[IDX_W-1:0];
            ord_wdata.key = ord_rdata.key;
            ord_wdata.idx = (ord_rdata.idx > fidx) ? ord_rdata.idx - IDX_W'(1)
                                                   : ord_rdata.idx;
            wptr_next     = wptr + CNT_W'(1);
          end
          if (scan_end) count_next = cnt_last;
        end
      end
      S_PLAY_ORD: begin
        ord_re    = 1'b1;
        ord_raddr = k[IDX_W-1:0];
      end
      S_PLAY_ENT: begin
        ent_re    = 1'b1;
        ent_raddr = sorted ? ord_rdata.idx : k[IDX_W-1:0];
      end
      S_PLAY_EMIT: begin
        out_data = '{status: STS_OK, track_id: ent_rdata.id,
                     track_artist: ent_rdata.artist, track_duration: ent_rdata.dur,
                     running_total: total_sum, last: play_last};
        if (out_free) begin
          out_load   = 1'b1;
          total_next = total_sum;
          k_next     = k + CNT_W'(1);
        end
      end
      S_RESP: begin
        out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      count   <= '0;
      next_id <= '0;
      dvalid  <= 1'b0;
      found   <= 1'b0;
    end else begin
      state   <= state_next;
      count   <= count_next;
      next_id <= next_id_next;
      dvalid  <= dvalid_next;
      found   <= found_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      c_func <= func_t'(cmd.func);
      c_key  <= cmd.artist_key;
      c_dur  <= cmd.duration_sec;
      c_tid  <= cmd.target_id;
    end
    j        <= j_next;
    rptr     <= rptr_next;
    dptr     <= dptr_next;
    wptr     <= wptr_next;
    fidx     <= fidx_next;
    k        <= k_next;
    total    <= total_next;
    r_status <= r_status_next;
    r_id     <= r_id_next;
  end

endmodule

[hw/rtl/track_table_with_sorted_readout.sv]
// Track table: add does a sorted insert that walks down the index (skipped if full),
// remove scans the entries and then compacts the index (no compaction if absent or empty),
// playback reads the entry in insertion order, or the index and then the entry when sorted.
// One command at a time; each memory has a single registered read port.
// Reset clears the entry count and the id counter; the memories
// are not cleared, and no clearing pass runs.
module track_table_with_sorted_readout
  import ttsr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  ttsr_cmd_if.sink   cmd,
  ttsr_res_if.source res
);

  logic             ent_we, ent_re, ord_we, ord_re;
  logic [IDX_W-1:0] ent_waddr, ent_raddr, ord_waddr, ord_raddr;
  ent_t             ent_wdata, ent_rdata;
  ord_t             ord_wdata, ord_rdata;
  logic             out_load, out_free;
  res_t             out_data;

  ttsr_ram #(.WIDTH($bits(ent_t)), .DEPTH(CAPACITY)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rdata)
  );

  ttsr_ram #(.WIDTH($bits(ord_t)), .DEPTH(CAPACITY)) u_ord_ram (
    .clk   (clk),
    .we    (ord_we),
    .waddr (ord_waddr),
    .wdata (ord_wdata),
    .re    (ord_re),
    .raddr (ord_raddr),
    .rdata (ord_rdata)
  );

  ttsr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .ent_we    (ent_we),
    .ent_waddr (ent_waddr),
    .ent_wdata (ent_wdata),
    .ent_re    (ent_re),
    .ent_raddr (ent_raddr),
    .ent_rdata (ent_rdata),
    .ord_we    (ord_we),
    .ord_waddr (ord_waddr),
    .ord_wdata (ord_wdata),
    .ord_re    (ord_re),
    .ord_raddr (ord_raddr),
    .ord_rdata (ord_rdata),
    .out_load  (out_load),
    .out_data  (out_data),
    .out_free  (out_free)
  );

  ttsr_out u_out (
    .clk  (clk),
    .rst  (rst),
    .load (out_load),
    .data (out_data),
    .free (out_free),
    .res  (res)
  );

endmodule

[hw/rtl/ttsr_chk.sv]
// Port-level checker for the track table, bound to the top level.
// Depends on ttsr_pkg and the assertion macro header.
`include "track_table_with_sorted_readout_macros.svh"

module ttsr_chk
  import ttsr_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             cmd_valid,
  input logic             cmd_ready,
  input logic             res_valid,
  input logic             res_ready,
  input logic [1:0]       res_status,
  input logic [ID_W-1:0]  res_track_id,
  input logic [TOT_W-1:0] res_running_total,
  input logic             res_last
);

  `TTSR_ASSERT_NXT(a_busy_after_cmd, clk, rst, cmd_valid && cmd_ready, !cmd_ready, "ready after command transfer")
  `TTSR_ASSERT_IMP(a_err_is_last, clk, rst, res_valid && res_status != STS_OK, res_last, "error result not last")
  `TTSR_ASSERT_IMP(a_err_no_total, clk, rst, res_valid && res_status != STS_OK, res_running_total == '0, "error result carries total")
  `TTSR_ASSERT_NXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(res_track_id), "stalled result changed")

endmodule

bind track_table_with_sorted_readout ttsr_chk u_ttsr_chk (
  .clk               (clk),
  .rst               (rst),
  .cmd_valid         (cmd.valid),
  .cmd_ready         (cmd.ready),
  .res_valid         (res.valid),
  .res_ready         (res.ready),
  .res_status        (res.status),
  .res_track_id      (res.track_id),
  .res_running_total (res.running_total),
  .res_last          (res.last)
);

[dv/track_table_with_sorted_readout_tb.sv]
`timescale 1ns / 100ps
// Self-checking testbench for track_table_with_sorted_readout: directed and random
// commands, every result checked against a table predictor kept in the bench.
// Depends on ttsr_pkg and the ttsr_cmd_if / ttsr_res_if interfaces.
module track_table_with_sorted_readout_tb;
  import ttsr_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 300;
  localparam int MAX_REPORTS    = 10;

  typedef struct {
    func_t            func;
    logic [KEY_W-1:0] artist;
    logic [DUR_W-1:0] dur;
    logic [ID_W-1:0]  target;
    bit               hold;
  } track_cmd_t;

  typedef enum int {
    GEN_MIX,
    GEN_FILL,
    GEN_DRAIN
  } gen_mode_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ttsr_cmd_if cmd_ch();
  ttsr_res_if res_ch();

  track_table_with_sorted_readout dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd_ch),
    .res(res_ch)
  );

  always #5 clk = ~clk;

  // Predicted table contents, updated at each command transfer.
  logic [ID_W-1:0]  tbl_id     [CAPACITY];
  logic [KEY_W-1:0] tbl_artist [CAPACITY];
  logic [DUR_W-1:0] tbl_dur    [CAPACITY];
  int               tbl_count   = 0;
  logic [ID_W-1:0]  tbl_next_id = '0;

  track_cmd_t cmd_backlog[$];
  res_t       track_expect[$];
  track_cmd_t cmd_on_bus;
  res_t       seen_res;
  res_t       owed_res;

  int src_idle_pct = 10;
  int snk_idle_pct = 81;
  int err_count    = 0;
  int result_count = 0;
  int stall_cycles = 0;

  task automatic flag_error(input string what);
    err_count++;
    if (err_count <= MAX_REPORTS) $display("ERROR @%0t: %s", $time, what);
  endtask

  function automatic res_t mk_result(status_t sts, logic [ID_W-1:0] id,
                                     logic [KEY_W-1:0] art, logic [DUR_W-1:0] dur,
                                     logic [TOT_W-1:0] tot, logic lst);
    res_t r;
    r.status         = sts;
    r.track_id       = id;
    r.track_artist   = art;
    r.track_duration = dur;
    r.running_total  = tot;
    r.last           = lst;
    return r;
  endfunction

  task automatic apply_track_cmd(input track_cmd_t c);
    int               order [CAPACITY];
    int               hit;
    int               pos;
    int               v;
    logic [TOT_W-1:0] total;
    case (c.func)
      FN_ADD: begin
        if (tbl_count >= CAPACITY) begin
          track_expect.push_back(mk_result(STS_FULL, '0, '0, '0, '0, 1'b1));
        end else begin
          tbl_id[tbl_count]     = tbl_next_id;
          tbl_artist[tbl_count] = c.artist;
          tbl_dur[tbl_count]    = c.dur;
          tbl_count++;
          track_expect.push_back(mk_result(STS_OK, tbl_next_id, '0, '0, '0, 1'b1));
          tbl_next_id = tbl_next_id + 1'b1;
        end
      end
      FN_REMOVE: begin
        hit = -1;
        for (int i = 0; i < tbl_count; i++) begin
          if (hit < 0 && tbl_id[i] == c.target) hit = i;
        end
        if (tbl_count == 0) begin
          track_expect.push_back(mk_result(STS_EMPTY, c.target, '0, '0, '0, 1'b1));
        end else if (hit < 0) begin
          track_expect.push_back(mk_result(STS_NOT_FOUND, c.target, '0, '0, '0, 1'b1));
        end else begin
          // close the gap, oldest match only
          for (int i = hit; i < tbl_count - 1; i++) begin
            tbl_id[i]     = tbl_id[i + 1];
            tbl_artist[i] = tbl_artist[i + 1];
            tbl_dur[i]    = tbl_dur[i + 1];
          end
          tbl_count--;
          track_expect.push_back(mk_result(STS_OK, c.target, '0, '0, '0, 1'b1));
        end
      end
      default: begin
        if (tbl_count == 0) begin
          track_expect.push_back(mk_result(STS_EMPTY, '0, '0, '0, '0, 1'b1));
        end else begin
          for (int i = 0; i < tbl_count; i++) order[i] = i;
          if (c.func == FN_PLAY_ARTIST) begin
            // stable: only strictly greater keys move up
            for (int i = 1; i < tbl_count; i++) begin
              v   = order[i];
              pos = i;
              while (pos > 0 && tbl_artist[order[pos - 1]] > tbl_artist[v]) begin
                order[pos] = order[pos - 1];
                pos--;
              end
              order[pos] = v;
            end
          end
          total = '0;
          for (int k = 0; k < tbl_count; k++) begin
            total = total + tbl_dur[order[k]];
            track_expect.push_back(mk_result(STS_OK, tbl_id[order[k]], tbl_artist[order[k]],
                                             tbl_dur[order[k]], total,
                                             k == tbl_count - 1));
          end
        end
      end
    endcase
  endtask

  function automatic track_cmd_t dir_cmd(func_t f, logic [KEY_W-1:0] a,
                                         logic [DUR_W-1:0] d, logic [ID_W-1:0] t, bit h);
    track_cmd_t c;
    c.func   = f;
    c.artist = a;
    c.dur    = d;
    c.target = t;
    c.hold   = h;
    return c;
  endfunction

  function automatic track_cmd_t make_track_cmd(gen_mode_t mode);
    track_cmd_t c;
    int         roll;
    roll = $urandom_range(99);
    if (roll < 35) c.func = FN_ADD;
    else if (roll < 65) c.func = FN_REMOVE;
    else if (roll < 80) c.func = FN_PLAY_INS;
    else c.func = FN_PLAY_ARTIST;
    if (mode == GEN_FILL && tbl_count < CAPACITY && $urandom_range(99) < 80) c.func = FN_ADD;
    if (mode == GEN_DRAIN && $urandom_range(99) < 85) c.func = FN_REMOVE;
    // a small key pool gives equal keys for the stable sort
    case ($urandom_range(9))
      0: c.artist = '0;
      1: c.artist = '1;
      2: c.artist = 64'h8000_0000_0000_0000;
      3: c.artist = 64'h0123_4567_89AB_CDEF;
      default: c.artist = {$urandom(), $urandom()};
    endcase
    case ($urandom_range(9))
      0: c.dur = '0;
      1: c.dur = '1;
      default: c.dur = DUR_W'($urandom_range(65535));
    endcase
    if (tbl_count > 0 && $urandom_range(99) < 80) begin
      c.target = tbl_id[$urandom_range(tbl_count - 1)];
    end else begin
      c.target = ID_W'($urandom_range(65535));
    end
    c.hold = ($urandom_range(99) < 4);
    return c;
  endfunction

  // Keep the backlog short so generated removes see a near-current table.
  task automatic queue_cmd(input track_cmd_t c);
    while (cmd_backlog.size() >= 2) @(negedge clk);
    cmd_backlog.push_back(c);
  endtask

  task automatic wait_quiet();
    while (cmd_backlog.size() != 0 || cmd_ch.valid || track_expect.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Command driver: predict on each transfer, then offer the next item.
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else begin
      if (cmd_ch.valid && cmd_ch.ready) apply_track_cmd(cmd_on_bus);
      if (!cmd_ch.valid || cmd_ch.ready) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= src_idle_pct &&
            !(cmd_backlog[0].hold && track_expect.size() != 0)) begin
          cmd_on_bus = cmd_backlog.pop_front();
          cmd_ch.valid        <= 1'b1;
          cmd_ch.func         <= cmd_on_bus.func;
          cmd_ch.artist_key   <= cmd_on_bus.artist;
          cmd_ch.duration_sec <= cmd_on_bus.dur;
          cmd_ch.target_id    <= cmd_on_bus.target;
        end else begin
          cmd_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each transfer with the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid && res_ch.ready) begin
        seen_res.status         = status_t'(res_ch.status);
        seen_res.track_id       = res_ch.track_id;
        seen_res.track_artist   = res_ch.track_artist;
        seen_res.track_duration = res_ch.track_duration;
        seen_res.running_total  = res_ch.running_total;
        seen_res.last           = res_ch.last;
        result_count++;
        if (track_expect.size() == 0) begin
          flag_error($sformatf("unexpected result %0d: sts=%0d id=%h", result_count,
                               seen_res.status, seen_res.track_id));
        end else begin
          owed_res = track_expect.pop_front();
          if (seen_res.status != owed_res.status ||
              seen_res.track_id != owed_res.track_id ||
              seen_res.track_artist != owed_res.track_artist ||
              seen_res.track_duration != owed_res.track_duration ||
              seen_res.running_total != owed_res.running_total ||
              seen_res.last != owed_res.last) begin
            flag_error($sformatf(
              "result %0d: exp sts=%0d id=%h art=%h dur=%h tot=%h last=%b, got sts=%0d %s",
              result_count, owed_res.status, owed_res.track_id, owed_res.track_artist,
              owed_res.track_duration, owed_res.running_total, owed_res.last,
              seen_res.status,
              $sformatf("id=%h art=%h dur=%h tot=%h last=%b", seen_res.track_id,
                        seen_res.track_artist, seen_res.track_duration,
                        seen_res.running_total, seen_res.last)));
          end
        end
      end
      res_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  // Watchdog: count cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles, %0d results still owed",
               stall_cycles, track_expect.size());
      $display("** track_table_with_sorted_readout: FAILED **");
      $finish;
    end
  end

  initial begin
    logic [ID_W-1:0] oldest_id;
    int              guard;

    cmd_ch.valid        = 1'b0;
    cmd_ch.func         = FN_ADD;
    cmd_ch.artist_key   = '0;
    cmd_ch.duration_sec = '0;
    cmd_ch.target_id    = '0;
    res_ch.ready        = 1'b0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Phase 1: sender idles rarely, receiver often.
    queue_cmd(dir_cmd(FN_PLAY_INS, '0, '0, '0, 1'b0));
    queue_cmd(dir_cmd(FN_PLAY_ARTIST, '0, '0, '0, 1'b0));
    queue_cmd(dir_cmd(FN_REMOVE, '0, '0, 16'hFFFF, 1'b0));
    queue_cmd(dir_cmd(FN_ADD, '0, '0, '0, 1'b0));
    queue_cmd(dir_cmd(FN_ADD, '1, '1, '0, 1'b0));
    queue_cmd(dir_cmd(FN_ADD, 64'h8000_0000_0000_0000, 16'd1, '0, 1'b0));
    queue_cmd(dir_cmd(FN_ADD, 64'h5555_5555_5555_5555, 16'hAAAA, '0, 1'b0));
    queue_cmd(dir_cmd(FN_ADD, 64'h5555_5555_5555_5555, 16'h5555, '0, 1'b0));
    queue_cmd(dir_cmd(FN_ADD, 64'h1, 16'h8000, '0, 1'b0));
    queue_cmd(dir_cmd(FN_PLAY_ARTIST, '0, '0, '0, 1'b1));
    queue_cmd(dir_cmd(FN_PLAY_INS, '0, '0, '0, 1'b0));
    queue_cmd(dir_cmd(FN_REMOVE, '0, '0, 16'hBEEF, 1'b0));
    queue_cmd(dir_cmd(FN_REMOVE, '0, '0, 16'd2, 1'b0));
    queue_cmd(dir_cmd(FN_REMOVE, '0, '0, 16'd0, 1'b0));
    queue_cmd(dir_cmd(FN_REMOVE, '0, '0, 16'd5, 1'b0));
    queue_cmd(dir_cmd(FN_PLAY_ARTIST, '0, '0, '0, 1'b0));
    queue_cmd(dir_cmd(FN_REMOVE, '0, '0, 16'd2, 1'b0));
    queue_cmd(dir_cmd(FN_ADD, 64'hAAAA_AAAA_AAAA_AAAA, 16'd7, '0, 1'b0));
    queue_cmd(dir_cmd(FN_PLAY_INS, '0, '0, '0, 1'b1));
    for (int i = 0; i < 4; i++) queue_cmd(make_track_cmd(GEN_MIX));

    // Phase 2: swap idling; fill the table, hit it while full, then drain part of it.
    src_idle_pct = 81;
    snk_idle_pct = 10;
    guard = 0;
    while (tbl_count < CAPACITY && guard < 100) begin
      queue_cmd(make_track_cmd(GEN_FILL));
      guard++;
    end
    queue_cmd(dir_cmd(FN_ADD, '1, '1, '0, 1'b0));
    queue_cmd(dir_cmd(FN_PLAY_ARTIST, '0, '0, '0, 1'b0));
    queue_cmd(dir_cmd(FN_PLAY_INS, '0, '0, '0, 1'b1));
    guard = 0;
    while (tbl_count > CAPACITY - 12 && guard < 30) begin
      queue_cmd(make_track_cmd(GEN_DRAIN));
      guard++;
    end

    // Phase 3: no idling. Remove the oldest entry, then retry the same id.
    src_idle_pct = 0;
    snk_idle_pct = 0;
    wait_quiet();
    if (tbl_count == 0) begin
      queue_cmd(dir_cmd(FN_ADD, 64'h0123_4567_89AB_CDEF, 16'd30, '0, 1'b0));
      wait_quiet();
    end
    oldest_id = tbl_id[0];
    queue_cmd(dir_cmd(FN_ADD, 64'hFFFF_0000_FFFF_0000, 16'd100, '0, 1'b0));
    queue_cmd(dir_cmd(FN_ADD, '0, 16'd200, '0, 1'b0));
    queue_cmd(dir_cmd(FN_PLAY_INS, '0, '0, '0, 1'b0));
    queue_cmd(dir_cmd(FN_PLAY_ARTIST, '0, '0, '0, 1'b1));
    queue_cmd(dir_cmd(FN_REMOVE, '0, '0, oldest_id, 1'b0));
    queue_cmd(dir_cmd(FN_PLAY_INS, '0, '0, '0, 1'b0));
    queue_cmd(dir_cmd(FN_REMOVE, '0, '0, oldest_id, 1'b0));
    for (int i = 0; i < 6; i++) queue_cmd(make_track_cmd(GEN_MIX));

    wait_quiet();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (track_expect.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", track_expect.size()));
    end
    if (err_count == 0) begin
      $display("** track_table_with_sorted_readout: PASSED **");
    end else begin
      $display("** track_table_with_sorted_readout: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hw/rtl
hw/rtl/ttsr_pkg.sv
hw/rtl/ttsr_if.sv
hw/rtl/ttsr_ram.sv
hw/rtl/ttsr_out.sv
hw/rtl/ttsr_ctrl.sv
hw/rtl/track_table_with_sorted_readout.sv
hw/rtl/ttsr_chk.sv
dv/track_table_with_sorted_readout_tb.sv
